/* rtl/srs_pkg.sv */
`timescale 1ns / 1ps

package srs_pkg;

  // Field and accumulator widths
  localparam int SAMPLE_W    = 24;
  localparam int SAMPLE_BITS = 24;
  localparam int MAX_SAMPLES = 65535;
  localparam int CNT_W       = 16;
  localparam int SUM_W       = 41;
  localparam int SQSUM_W     = 62;
  localparam int SQ_W        = 2 * SAMPLE_BITS;
  localparam int RES_W       = 32;
  localparam int STAT_W      = 3;
  localparam int FRAC_BITS   = 20;

  // Closing arithmetic widths
  localparam int NUM_W   = SUM_W + 1;
  localparam int MUL_A_W = 64;
  localparam int MUL_B_W = 41;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int D_W     = 80;
  localparam int DVD_W   = D_W + 2 * FRAC_BITS;
  localparam int Q_W     = 64;

  // Sequencer step counts
  localparam int MUL_STEPS  = MUL_B_W;
  localparam int DIV_STEPS  = DVD_W;
  localparam int SQRT_STEPS = Q_W / 2;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 3'd0,
    ST_EMPTY = 3'd1,
    ST_ZVAR  = 3'd2,
    ST_SAT   = 3'd3,
    ST_DROP  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    MSEL_NS = 2'd0,  // count * square_sum
    MSEL_SS = 2'd1,  // |sum| * |sum|
    MSEL_MM = 2'd2   // |excess| * |excess|
  } mul_sel_t;

  typedef struct packed {
    logic     accept;
    logic     calc_num;
    logic     mul_start;
    mul_sel_t mul_sel;
    logic     mul_step;
    logic     save_d1;
    logic     save_d;
    logic     load_div;
    logic     div_step;
    logic     sqrt_load;
    logic     sqrt_step;
    logic     out_load;
    status_t  out_code;
  } dp_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic d_zero;
  } dp_stat_t;

endpackage

/* rtl/srs_in_if.sv */
`timescale 1ns / 1ps

interface srs_in_if import srs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_return;
  logic                has_sample;
  logic                last;

  modport source (output valid, sample_return, has_sample, last, input ready);
  modport sink   (input valid, sample_return, has_sample, last, output ready);
endinterface

/* rtl/srs_out_if.sv */
`timescale 1ns / 1ps

interface srs_out_if import srs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RES_W-1:0]  sharpe_ratio;
  logic [STAT_W-1:0] status;
  logic [CNT_W-1:0]  sample_count;

  modport source (output valid, sharpe_ratio, status, sample_count, input ready);
  modport sink   (input valid, sharpe_ratio, status, sample_count, output ready);
endinterface

/* rtl/srs_ctrl.sv */
`timescale 1ns / 1ps

module srs_ctrl import srs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_last,
  output logic     in_ready,
  input  logic     out_ready,
  output logic     out_valid,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_FLUSH, S_NS_LOAD, S_NS_MUL, S_SS_LOAD, S_SS_MUL, S_D_SUB, S_D_CHK,
    S_MM_MUL, S_DIV_LOAD, S_DIV, S_SQRT_LOAD, S_SQRT, S_DONE
  } state_t;

  state_t              state;
  logic [STEP_W-1:0]   cnt;
  status_t             code;

  assign in_ready = (state == S_IDLE);

  // State, step counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      code      <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && in_last) begin
            state <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (stat.count_zero) begin
            code  <= ST_EMPTY;
            state <= S_DONE;
          end else begin
            state <= S_NS_LOAD;
          end
        end
        S_NS_LOAD: begin
          cnt   <= STEP_W'(MUL_STEPS - 1);
          state <= S_NS_MUL;
        end
        S_NS_MUL: begin
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= S_SS_LOAD;
          end
        end
        S_SS_LOAD: begin
          cnt   <= STEP_W'(MUL_STEPS - 1);
          state <= S_SS_MUL;
        end
        S_SS_MUL: begin
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= S_D_SUB;
          end
        end
        S_D_SUB: begin
          state <= S_D_CHK;
        end
        S_D_CHK: begin
          if (stat.d_zero) begin
            code  <= ST_ZVAR;
            state <= S_DONE;
          end else begin
            cnt   <= STEP_W'(MUL_STEPS - 1);
            state <= S_MM_MUL;
          end
        end
        S_MM_MUL: begin
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= S_DIV_LOAD;
          end
        end
        S_DIV_LOAD: begin
          cnt   <= STEP_W'(DIV_STEPS - 1);
          state <= S_DIV;
        end
        S_DIV: begin
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= S_SQRT_LOAD;
          end
        end
        S_SQRT_LOAD: begin
          cnt   <= STEP_W'(SQRT_STEPS - 1);
          state <= S_SQRT;
        end
        S_SQRT: begin
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            code  <= ST_OK;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath command decode
  always_comb begin
    cmd          = '0;
    cmd.mul_sel  = MSEL_NS;
    cmd.out_code = code;
    case (state)
      S_IDLE:      cmd.accept = in_valid;
      S_FLUSH:     cmd.calc_num = 1'b1;
      S_NS_LOAD: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MSEL_NS;
      end
      S_NS_MUL:    cmd.mul_step = 1'b1;
      S_SS_LOAD: begin
        cmd.save_d1   = 1'b1;
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MSEL_SS;
      end
      S_SS_MUL:    cmd.mul_step = 1'b1;
      S_D_SUB:     cmd.save_d = 1'b1;
      S_D_CHK: begin
        cmd.mul_start = !stat.d_zero;
        cmd.mul_sel   = MSEL_MM;
      end
      S_MM_MUL:    cmd.mul_step = 1'b1;
      S_DIV_LOAD:  cmd.load_div = 1'b1;
      S_DIV:       cmd.div_step = 1'b1;
      S_SQRT_LOAD: cmd.sqrt_load = 1'b1;
      S_SQRT:      cmd.sqrt_step = 1'b1;
      S_DONE:      cmd.out_load = !out_valid || out_ready;
      default:     cmd.accept = 1'b0;
    endcase
  end

endmodule

/* rtl/srs_datapath.sv */
`timescale 1ns / 1ps

module srs_datapath import srs_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  input  logic [SAMPLE_W-1:0] sample_return,
  input  logic                has_sample,
  input  logic                cfg_we,
  input  logic [SAMPLE_W-1:0] cfg_wdata,
  output logic [RES_W-1:0]    sharpe_ratio,
  output status_t             status,
  output logic [CNT_W-1:0]    sample_count
);

  // Accumulators and configuration
  logic [SAMPLE_W-1:0]       rf_rate;
  logic signed [SUM_W-1:0]   return_sum;
  logic [SQSUM_W-1:0]        square_sum;
  logic [CNT_W-1:0]          count;
  logic                      dropped_flag;
  logic [SQ_W-1:0]           sq;
  logic                      sq_vld;

  // Closing arithmetic registers
  logic                      num_neg;
  logic [MUL_B_W-1:0]        num_mag;
  logic [MUL_A_W-1:0]        mul_a;
  logic [PROD_W-1:0]         prod;
  logic [D_W-1:0]            d1;
  logic [D_W-1:0]            d;
  logic [DVD_W-1:0]          dvd;
  logic [D_W-1:0]            rem;
  logic [Q_W-1:0]            quo;
  logic                      sticky;
  logic [Q_W-1:0]            sx;
  logic [Q_W-1:0]            sres;
  logic [Q_W-1:0]            sbit;

  logic signed [SAMPLE_BITS-1:0]  s;
  logic signed [SQ_W-1:0]         sq_full;
  logic signed [SAMPLE_BITS-1:0]  rf_s;
  logic signed [SUM_W-1:0]        nrf;
  logic signed [NUM_W-1:0]        num;
  logic [NUM_W-1:0]               num_abs;
  logic [SUM_W-1:0]               sum_mag;
  logic [MUL_A_W-1:0]             a_sel;
  logic [MUL_B_W-1:0]             b_sel;
  logic [MUL_A_W:0]               mul_sum;
  logic [D_W:0]                   rem_sh;
  logic                           rem_ge;
  logic [Q_W:0]                   trial;
  logic                           sq_ge;
  logic [RES_W:0]                 root;
  logic [RES_W:0]                 limit;
  logic                           sat;
  logic [RES_W:0]                 qv;

  assign s       = signed'(sample_return[SAMPLE_BITS-1:0]);
  assign sq_full = s * s;
  assign rf_s    = signed'(rf_rate[SAMPLE_BITS-1:0]);
  assign nrf     = signed'({1'b0, count}) * rf_s;
  assign num     = NUM_W'(return_sum) - NUM_W'(nrf);
  assign num_abs = num[NUM_W-1] ? NUM_W'(-num) : unsigned'(num);
  assign sum_mag = return_sum[SUM_W-1] ? SUM_W'(-return_sum) : unsigned'(return_sum);

  assign stat.count_zero = (count == '0);
  assign stat.d_zero     = (d == '0);

  // Sample accumulation; the square is registered and added in the cycle after its item
  always_ff @(posedge clk) begin
    if (rst) begin
      rf_rate      <= '0;
      return_sum   <= '0;
      square_sum   <= '0;
      count        <= '0;
      dropped_flag <= 1'b0;
      sq_vld       <= 1'b0;
    end else begin
      if (cfg_we) begin
        rf_rate <= cfg_wdata;
      end
      sq_vld <= 1'b0;
      if (cmd.accept && has_sample) begin
        if (count == CNT_W'(MAX_SAMPLES)) begin
          dropped_flag <= 1'b1;
        end else begin
          return_sum <= return_sum + SUM_W'(s);
          count      <= count + 1'b1;
          sq_vld     <= 1'b1;
        end
      end
      if (sq_vld) begin
        square_sum <= square_sum + SQSUM_W'(sq);
      end
      if (cmd.out_load) begin
        return_sum   <= '0;
        square_sum   <= '0;
        count        <= '0;
        dropped_flag <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    sq <= unsigned'(sq_full);
  end

  // Shared shift-add multiplier operands
  always_comb begin
    case (cmd.mul_sel)
      MSEL_NS: begin
        a_sel = MUL_A_W'(square_sum);
        b_sel = MUL_B_W'(count);
      end
      MSEL_SS: begin
        a_sel = MUL_A_W'(sum_mag);
        b_sel = MUL_B_W'(sum_mag);
      end
      MSEL_MM: begin
        a_sel = MUL_A_W'(num_mag);
        b_sel = num_mag;
      end
      default: begin
        a_sel = '0;
        b_sel = '0;
      end
    endcase
  end

  assign mul_sum = prod[0] ? {1'b0, prod[PROD_W-1:MUL_B_W]} + {1'b0, mul_a}
                           : {1'b0, prod[PROD_W-1:MUL_B_W]};

  // Restoring division step, one quotient bit a cycle
  assign rem_sh = {rem, dvd[DVD_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, d});

  // Integer square root step, two radicand bits a cycle
  assign trial = {1'b0, sres} + {1'b0, sbit};
  assign sq_ge = ({1'b0, sx} >= trial);

  // Closing sequence registers
  always_ff @(posedge clk) begin
    if (cmd.calc_num) begin
      num_neg <= num[NUM_W-1];
      num_mag <= MUL_B_W'(num_abs);
    end
    if (cmd.mul_start) begin
      mul_a <= a_sel;
      prod  <= PROD_W'(b_sel);
    end else if (cmd.mul_step) begin
      prod <= {mul_sum, prod[MUL_B_W-1:1]};
    end
    if (cmd.save_d1) begin
      d1 <= prod[D_W-1:0];
    end
    if (cmd.save_d) begin
      d <= d1 - prod[D_W-1:0];
    end
    if (cmd.load_div) begin
      dvd    <= DVD_W'(prod[D_W-1:0]) << (2 * FRAC_BITS);
      rem    <= '0;
      quo    <= '0;
      sticky <= 1'b0;
    end else if (cmd.div_step) begin
      dvd    <= dvd << 1;
      rem    <= rem_ge ? D_W'(rem_sh - {1'b0, d}) : rem_sh[D_W-1:0];
      quo    <= {quo[Q_W-2:0], rem_ge};
      sticky <= sticky | quo[Q_W-1];
    end
    if (cmd.sqrt_load) begin
      sx   <= quo;
      sres <= '0;
      sbit <= Q_W'(1) << (Q_W - 2);
    end else if (cmd.sqrt_step) begin
      if (sq_ge) begin
        sx   <= sx - trial[Q_W-1:0];
        sres <= (sres >> 1) + sbit;
      end else begin
        sres <= sres >> 1;
      end
      sbit <= sbit >> 2;
    end
  end

  // Saturation and sign of the final result
  assign root  = sres[RES_W:0];
  assign limit = num_neg ? (RES_W+1)'(1) << (RES_W - 1)
                         : ((RES_W+1)'(1) << (RES_W - 1)) - 1'b1;
  assign sat   = sticky || (root > limit);
  assign qv    = sat ? limit : root;

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      sample_count <= count;
      if (cmd.out_code != ST_OK) begin
        sharpe_ratio <= '0;
        status       <= cmd.out_code;
      end else begin
        sharpe_ratio <= num_neg ? RES_W'(-qv[RES_W-1:0]) : qv[RES_W-1:0];
        if (sat) begin
          status <= ST_SAT;
        end else if (dropped_flag) begin
          status <= ST_DROP;
        end else begin
          status <= ST_OK;
        end
      end
    end
  end

endmodule

/* rtl/sharpe_ratio_stream.sv */
`timescale 1ns / 1ps

// Channel   Role     Handshake      Payload
// samples   input    valid/ready    sample_return[23:0], has_sample, last
// results   output   valid/ready    sharpe_ratio[31:0], status[2:0], sample_count[15:0]
// cfg       write    cfg_we         cfg_wdata[23:0] -> rf_rate
//
// A series item is taken every cycle while intake is open; one 24x24 multiplier
// squares each sample. After an item with last set, intake stays low until the
// result is loaded: three 41-step shift-add multiplies, a 120-step divide and a
// 32-step square root. An empty series skips these, a flat one the last three.
// rst is synchronous and clears the accumulators and the risk-free rate.
// A result waits in the output register while the next series streams in.

module sharpe_ratio_stream import srs_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  srs_in_if.sink              samples,
  srs_out_if.source           results,
  input  logic                cfg_we,
  input  logic [SAMPLE_W-1:0] cfg_wdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  status_t  status;

  srs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_last   (samples.last),
    .in_ready  (samples.ready),
    .out_ready (results.ready),
    .out_valid (results.valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  srs_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .sample_return (samples.sample_return),
    .has_sample    (samples.has_sample),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .sharpe_ratio  (results.sharpe_ratio),
    .status        (status),
    .sample_count  (results.sample_count)
  );

  assign results.status = status;

  // Closing item stops intake on the next cycle
  a_close_blocks: assert property (@(posedge clk) disable iff (rst)
    (samples.valid && samples.ready && samples.last) |=> !samples.ready)
    else $error("intake still open after closing item");

  // Result register is never overwritten while a result waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!results.valid || results.ready))
    else $error("pending result overwritten");

  // Empty series reports no samples
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.status == ST_EMPTY) |-> (results.sample_count == '0))
    else $error("empty series with nonzero count");

  // Empty and flat series give a zero ratio
  a_zero_ratio: assert property (@(posedge clk) disable iff (rst)
    (results.valid && (results.status == ST_EMPTY || results.status == ST_ZVAR))
      |-> (results.sharpe_ratio == '0))
    else $error("nonzero ratio on empty or flat series");

endmodule

/* dv/tb_sharpe_ratio_stream.sv */
`timescale 1ns / 1ps

module tb_sharpe_ratio_stream;
  import srs_pkg::*;

  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int SETTLE_CYCLES = 300;   // longer than a closing pass
  localparam int HOLD_CYCLES   = 1500;
  localparam int IDLE_PCT      = 36;
  localparam int RANDOM_ITEMS  = 1400;
  localparam int RAND_PHASES   = 8;
  localparam int QUIET_PHASE   = 4;
  localparam int REPORT_LIMIT  = 10;

  localparam logic [SAMPLE_W-1:0] SMP_MAX = 24'h7F_FFFF;
  localparam logic [SAMPLE_W-1:0] SMP_MIN = 24'h80_0000;

  // Value mixes for the samples of one random series
  typedef enum int {MIX_FULL, MIX_CLUSTER, MIX_SMALL, MIX_EXTREME} mix_t;

  typedef struct packed {
    logic [RES_W-1:0] ratio;
    status_t          status;
    logic [CNT_W-1:0] count;
  } sharpe_result_t;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [SAMPLE_W-1:0] cfg_wdata;

  srs_in_if  samples_if ();
  srs_out_if results_if ();

  sharpe_ratio_stream dut (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples_if),
    .results   (results_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor state: running series plus the risk-free rate register
  longint              acc_sum     = 0;
  logic [63:0]         acc_sqsum   = '0;
  int unsigned         acc_count   = 0;
  bit                  acc_dropped = 1'b0;
  logic [SAMPLE_W-1:0] rf_reg      = '0;

  sharpe_result_t expected_results[$];
  sharpe_result_t result_head;

  int mismatches   = 0;
  int cycle_count  = 0;
  int in_idle_pct  = IDLE_PCT;
  int out_idle_pct = IDLE_PCT;
  int ready_hold   = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_sharpe_ratio_stream: errors");
      $finish;
    end
  end

  function automatic logic [63:0] magnitude_of(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // Floor square root, one result bit per step
  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] root;
    logic [63:0] trial;
    int          i;
    root = '0;
    for (i = 31; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (128'(trial) * 128'(trial) <= 128'(x)) root = trial;
    end
    return root;
  endfunction

  // Accumulate one accepted item; on last, queue the expected result
  task automatic predict_sharpe(input logic [SAMPLE_W-1:0] smp, input logic hs,
                                input logic lst);
    longint         s;
    longint         rf;
    longint         excess;
    logic [63:0]    mag;
    logic [63:0]    root;
    logic [63:0]    lim;
    logic [63:0]    neg;
    logic [127:0]   dvar;
    logic [127:0]   quot;
    sharpe_result_t r;
    if (hs) begin
      if (acc_count >= MAX_SAMPLES) begin
        acc_dropped = 1'b1;
      end else begin
        s = $signed(smp);
        acc_sum += s;
        acc_sqsum += 64'(s * s);
        acc_count++;
      end
    end
    if (!lst) return;
    r.ratio  = '0;
    r.status = ST_OK;
    r.count  = acc_count[CNT_W-1:0];
    if (acc_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      mag  = magnitude_of(acc_sum);
      dvar = 128'(acc_count) * 128'(acc_sqsum) - 128'(mag) * 128'(mag);
      if (dvar == '0) begin
        r.status = ST_ZVAR;
      end else begin
        rf     = $signed(rf_reg);
        excess = acc_sum - longint'(acc_count) * rf;
        mag    = magnitude_of(excess);
        // ratio^2 in Q.40, then the root gives Q.20
        quot   = ((128'(mag) * 128'(mag)) << 40) / dvar;
        lim    = (excess < 0) ? 64'h8000_0000 : 64'h7FFF_FFFF;
        root   = (quot[127:64] != '0) ? lim + 64'd1 : int_sqrt(quot[63:0]);
        if (root > lim) begin
          root     = lim;
          r.status = ST_SAT;
        end
        neg     = 64'd0 - root;
        r.ratio = (excess < 0) ? neg[RES_W-1:0] : root[RES_W-1:0];
        if (r.status == ST_OK && acc_dropped) r.status = ST_DROP;
      end
    end
    expected_results.push_back(r);
    acc_sum     = 0;
    acc_sqsum   = '0;
    acc_count   = 0;
    acc_dropped = 1'b0;
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("mismatch %s: expected %0h actual %0h", what, want, got);
  endtask

  // Result checker
  always @(posedge clk) begin
    if (!rst && results_if.valid && results_if.ready) begin
      if (expected_results.size() == 0) begin
        note_mismatch("unexpected result", '0, results_if.sharpe_ratio);
      end else begin
        result_head = expected_results.pop_front();
        if (results_if.sharpe_ratio !== result_head.ratio)
          note_mismatch("sharpe_ratio", result_head.ratio, results_if.sharpe_ratio);
        if (results_if.status !== result_head.status)
          note_mismatch("status", 32'(result_head.status), 32'(results_if.status));
        if (results_if.sample_count !== result_head.count)
          note_mismatch("sample_count", 32'(result_head.count),
                        32'(results_if.sample_count));
      end
    end
  end

  // Result receiver: random stalls, or a long hold when requested
  initial begin
    results_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (ready_hold > 0) begin
        ready_hold--;
        results_if.ready <= 1'b0;
      end else begin
        results_if.ready <= ($urandom_range(0, 99) >= out_idle_pct);
      end
    end
  end

  // Offer one item, with random gaps first; returns at the accepting edge
  task automatic send_item(input logic [SAMPLE_W-1:0] smp, input logic hs,
                           input logic lst);
    @(negedge clk);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      samples_if.valid         <= 1'b0;
      samples_if.sample_return <= SAMPLE_W'($urandom);
      samples_if.has_sample    <= 1'($urandom);
      samples_if.last          <= 1'($urandom);
      @(negedge clk);
    end
    samples_if.valid         <= 1'b1;
    samples_if.sample_return <= smp;
    samples_if.has_sample    <= hs;
    samples_if.last          <= lst;
    do @(posedge clk); while (!samples_if.ready);
    predict_sharpe(smp, hs, lst);
  endtask

  // Stop offering, wait out all pending results, then settle
  task automatic wait_quiet(input int settle);
    @(negedge clk);
    samples_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_rf(input logic [SAMPLE_W-1:0] value);
    wait_quiet(SETTLE_CYCLES);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    rf_reg = value;
  endtask

  function automatic logic [SAMPLE_W-1:0] draw_sample(input mix_t mix,
                                                      input logic [SAMPLE_W-1:0] base);
    case (mix)
      MIX_FULL:    return SAMPLE_W'($urandom);
      MIX_CLUSTER: return base + SAMPLE_W'($urandom_range(0, 3));
      MIX_SMALL:   return SAMPLE_W'($urandom_range(0, 511)) - 24'd256;
      default: begin
        case ($urandom_range(0, 3))
          0:       return SMP_MAX;
          1:       return SMP_MIN;
          2:       return '0;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  // Directed corner cases, starting from the reset rate of zero
  task automatic test_special_cases();
    // empty series: bare end marker
    send_item(24'h12_3456, 1'b0, 1'b1);
    // single sample: zero variance
    send_item(SMP_MAX, 1'b1, 1'b1);
    // ignored marker, then both extremes
    send_item(24'h5A_5A5A, 1'b0, 1'b0);
    send_item(SMP_MIN, 1'b1, 1'b0);
    send_item(SMP_MAX, 1'b1, 1'b1);
    // constant series
    send_item(-24'd5, 1'b1, 1'b0);
    send_item(-24'd5, 1'b1, 1'b0);
    send_item(-24'd5, 1'b1, 1'b1);
    // series closed by a bare end marker
    send_item(24'd1000, 1'b1, 1'b0);
    send_item(-24'd3000, 1'b1, 1'b0);
    send_item(24'd7, 1'b1, 1'b0);
    send_item(SMP_MAX, 1'b0, 1'b1);
    // mean equal to the rate: zero excess
    write_rf(24'd20);
    send_item(24'd10, 1'b1, 1'b0);
    send_item(24'd30, 1'b1, 1'b1);
    // tiny variance, huge excess: saturates high
    write_rf(SMP_MIN);
    send_item(24'd100, 1'b1, 1'b0);
    send_item(24'd101, 1'b1, 1'b1);
    // and low
    write_rf(SMP_MAX);
    send_item(24'd100, 1'b1, 1'b0);
    send_item(24'd101, 1'b1, 1'b1);
    send_item(SMP_MIN, 1'b1, 1'b0);
    send_item(SMP_MAX, 1'b1, 1'b0);
    send_item(SMP_MIN, 1'b1, 1'b1);
  endtask

  // Random series under several rates, with stray and broken items
  task automatic test_random_series();
    int                  phase;
    int                  budget;
    int                  len;
    int                  i;
    mix_t                mix;
    logic [SAMPLE_W-1:0] base;
    logic                bare_close;
    for (phase = 0; phase < RAND_PHASES; phase++) begin
      case (phase)
        0:       write_rf('0);
        1:       write_rf(SMP_MAX);
        2:       write_rf(SMP_MIN);
        3:       write_rf(SAMPLE_W'($urandom_range(0, 2000)) - 24'd1000);
        default: write_rf(SAMPLE_W'($urandom));
      endcase
      if (phase == QUIET_PHASE) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end else begin
        in_idle_pct  = IDLE_PCT;
        out_idle_pct = IDLE_PCT;
      end
      budget = 0;
      while (budget < RANDOM_ITEMS / RAND_PHASES) begin
        if ($urandom_range(0, 99) < 8) begin
          // stray item: ignored marker or lone end marker
          if ($urandom_range(0, 1)) begin
            send_item(SAMPLE_W'($urandom), 1'b0, 1'b0);
          end else begin
            send_item(SAMPLE_W'($urandom), 1'b0, 1'b1);
            budget++;
          end
        end else begin
          len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12)
                                             : $urandom_range(13, 80);
          mix        = mix_t'($urandom_range(0, 3));
          base       = SAMPLE_W'($urandom);
          bare_close = ($urandom_range(0, 99) < 25);
          for (i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < 4) send_item(SAMPLE_W'($urandom), 1'b0, 1'b0);
            send_item(draw_sample(mix, base), 1'b1, !bare_close && (i == len - 1));
          end
          if (bare_close) send_item(SAMPLE_W'($urandom), 1'b0, 1'b1);
          budget += len + int'(bare_close);
          // sender pause until the block has caught up
          if ($urandom_range(0, 99) < 4) wait_quiet(0);
        end
      end
    end
    in_idle_pct  = IDLE_PCT;
    out_idle_pct = IDLE_PCT;
  endtask

  // Receiver holds off while short series keep coming: input must stall
  task automatic test_output_stall();
    int i;
    wait_quiet(0);
    ready_hold = HOLD_CYCLES;
    for (i = 0; i < 18; i++)
      send_item(SAMPLE_W'($urandom), 1'b1, (i % 3) == 2);
    wait_quiet(0);
  endtask

  // Main sequence
  initial begin
    rst                      = 1'b1;
    cfg_we                   = 1'b0;
    cfg_wdata                = '0;
    samples_if.valid         = 1'b0;
    samples_if.sample_return = '0;
    samples_if.has_sample    = 1'b0;
    samples_if.last          = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_special_cases();
    test_random_series();
    test_output_stall();

    wait_quiet(SETTLE_CYCLES);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb_sharpe_ratio_stream: clean");
    end else begin
      $display("tb_sharpe_ratio_stream: errors");
    end
    $finish;
  end

endmodule
